FILE: hw/rtl/lcrs_pkg.sv
// Shared types and constants for the lowercase count ranking block.
package lcrs_pkg;

  // Request function codes.
  localparam logic [1:0] FUNC_CHAR   = 2'd0;
  localparam logic [1:0] FUNC_CLOSE  = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Lowercase ASCII range and the saturation limit of a string count.
  localparam logic [7:0]  LC_FIRST  = 8'h61;
  localparam logic [7:0]  LC_LAST   = 8'h7A;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One input request.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] ch;
  } lcrs_req_t;

  // One ranking result.
  typedef struct packed {
    logic [3:0]  string_index;
    logic [15:0] lower_count;
    logic        empty_res;
    logic        last;
  } lcrs_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_char;
    logic do_close;
    logic do_finish;
    logic emit_empty;
    logic scan_step;
    logic emit;
  } lcrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic set_empty;
    logic scan_last;
    logic rank_last;
  } lcrs_stat_t;

endpackage

FILE: hw/rtl/lowercase_count_rank_sort.sv
// Top level of the lowercase count ranking block.
// A character or close request leaves busy low, so such requests can be
// issued every cycle. A finish request with stored strings holds busy while
// each rank is found by one pass over the count memory through its single
// read port, followed by a step in which the winner is resolved and sent;
// the final result carries last. A finish with no strings gives a single
// empty result in the next cycle. Each result is shown for exactly one cycle
// with res_valid_o high; the receiver must take it then, as there is no
// hold-off.
module lowercase_count_rank_sort
  import lcrs_pkg::*;
#(
  parameter int MAX_STRINGS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lcrs_req_t req_i,
  output lcrs_res_t res_o,
  output logic      res_valid_o
);

  lcrs_cmd_t  cmd;
  lcrs_stat_t stat;

  // Controller.
  lcrs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (req_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Datapath.
  lcrs_datapath #(
    .MaxStrings (MAX_STRINGS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

FILE: hw/rtl/lcrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lcrs_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/lcrs_datapath.sv
// Datapath: letter counter, count store, max-search scan and result register.
module lcrs_datapath
  import lcrs_pkg::*;
#(
  parameter int MaxStrings = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcrs_req_t  req_i,
  input  lcrs_cmd_t  cmd_i,
  output lcrs_stat_t stat_o,
  output lcrs_res_t  res_o,
  output logic       res_valid_o
);

  localparam int AW = (MaxStrings > 1) ? $clog2(MaxStrings) : 1;
  localparam int CW = $clog2(MaxStrings + 1);

  logic [15:0]         running_count_q;
  logic [CW-1:0]       strings_closed_q;
  logic [CW-1:0]       n_q;
  logic [CW-1:0]       rank_q;
  logic [AW-1:0]       rd_addr_q;
  logic [AW-1:0]       cmp_addr_q;
  logic                cmp_valid_q;
  logic                best_valid_q;
  logic [15:0]         best_cnt_q, best_cnt_d;
  logic [AW-1:0]       best_addr_q, best_addr_d;
  logic [MaxStrings-1:0] used_q;
  lcrs_res_t           res_q;
  logic                res_valid_q;

  logic        full;
  logic        is_lower;
  logic        take;
  logic [15:0] rd_data;

  assign full     = strings_closed_q >= CW'(MaxStrings);
  assign is_lower = (req_i.ch >= LC_FIRST) && (req_i.ch <= LC_LAST);

  // Count store; the string position is the address, so no order store is kept.
  lcrs_ram #(
    .Width (16),
    .Depth (MaxStrings)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_close && !full),
    .waddr_i (strings_closed_q[AW-1:0]),
    .wdata_i (running_count_q),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  // Scan compare: a strictly larger count replaces the best, so ties keep
  // the earliest string and the ranking stays stable.
  assign take = cmp_valid_q && !used_q[cmp_addr_q] &&
                (!best_valid_q || (rd_data > best_cnt_q));

  always_comb begin
    best_cnt_d  = best_cnt_q;
    best_addr_d = best_addr_q;
    if (take) begin
      best_cnt_d  = rd_data;
      best_addr_d = cmp_addr_q;
    end
  end

  // Status toward the controller.
  assign stat_o.set_empty = (strings_closed_q == '0);
  assign stat_o.scan_last = (CW'(rd_addr_q) == n_q - CW'(1));
  assign stat_o.rank_last = (rank_q == n_q - CW'(1));

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_count_q  <= '0;
      strings_closed_q <= '0;
      n_q              <= '0;
      rank_q           <= '0;
      rd_addr_q        <= '0;
      cmp_valid_q      <= 1'b0;
      best_valid_q     <= 1'b0;
      used_q           <= '0;
      res_valid_q      <= 1'b0;
    end else begin
      cmp_valid_q <= cmd_i.scan_step;
      res_valid_q <= cmd_i.emit || cmd_i.emit_empty;
      if (take && !cmd_i.emit) begin
        best_valid_q <= 1'b1;
      end
      if (cmd_i.do_char && !full && is_lower && (running_count_q < COUNT_MAX)) begin
        running_count_q <= running_count_q + 16'd1;
      end
      if (cmd_i.do_close) begin
        running_count_q <= '0;
        if (!full) begin
          strings_closed_q <= strings_closed_q + CW'(1);
        end
      end
      if (cmd_i.do_finish) begin
        n_q              <= strings_closed_q;
        running_count_q  <= '0;
        strings_closed_q <= '0;
        rank_q           <= '0;
        rd_addr_q        <= '0;
        best_valid_q     <= 1'b0;
        used_q           <= '0;
      end
      if (cmd_i.scan_step && !stat_o.scan_last) begin
        rd_addr_q <= rd_addr_q + AW'(1);
      end
      if (cmd_i.emit) begin
        used_q[best_addr_d] <= 1'b1;
        best_valid_q        <= 1'b0;
        rd_addr_q           <= '0;
        rank_q              <= rank_q + CW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_addr_q  <= rd_addr_q;
    best_cnt_q  <= best_cnt_d;
    best_addr_q <= best_addr_d;
    if (cmd_i.emit) begin
      res_q.string_index <= 4'(best_addr_d);
      res_q.lower_count  <= best_cnt_d;
      res_q.empty_res    <= 1'b0;
      res_q.last         <= stat_o.rank_last;
    end else if (cmd_i.emit_empty) begin
      res_q.string_index <= '0;
      res_q.lower_count  <= '0;
      res_q.empty_res    <= 1'b1;
      res_q.last         <= 1'b1;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

FILE: hw/rtl/lcrs_ctrl.sv
// Controller state machine: request decode and ranking scan sequencing.
module lcrs_ctrl
  import lcrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] func_i,
  input  lcrs_stat_t stat_i,
  output lcrs_cmd_t  cmd_o,
  output logic       busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state_q, state_d;

  assign busy = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (func_i)
            FUNC_CHAR:  cmd_o.do_char  = 1'b1;
            FUNC_CLOSE: cmd_o.do_close = 1'b1;
            FUNC_FINISH: begin
              cmd_o.do_finish = 1'b1;
              if (stat_i.set_empty) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        // The last compare of the pass resolves here and the winner is sent.
        cmd_o.emit = 1'b1;
        state_d    = stat_i.rank_last ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: tb/tb_lowercase_count_rank_sort.sv
// Self-checking testbench for the lowercase count ranking block.
module tb_lowercase_count_rank_sort;
  import lcrs_pkg::*;

  localparam int         MAX_STR   = 16;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // One row of the directed table; res holds a typed-in ranking for finish rows.
  typedef struct {
    lcrs_req_t req;
    int        reps;
    bit        typed;
    lcrs_res_t res;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      start       = 1'b0;
  lcrs_req_t req_i       = '0;
  logic      busy;
  lcrs_res_t res_o;
  logic      res_valid_o;

  // Sideband that travels with each request: a typed-in result replaces the prediction.
  bit        typed_req = 1'b0;
  lcrs_res_t typed_res = '0;

  // Predictor state: the open string and the strings kept so far.
  logic [15:0] open_count = '0;
  int          strings_kept = 0;
  logic [15:0] kept_count[MAX_STR];
  logic [3:0]  kept_pos[MAX_STR];

  lcrs_res_t ranked_q[$];
  stim_row_t stim_rows[$];

  int  err_cnt     = 0;
  int  req_cnt     = 0;
  int  finish_cnt  = 0;
  int  checked_cnt = 0;
  bit  calm_run    = 1'b0;

  lowercase_count_rank_sort #(.MAX_STRINGS(MAX_STR)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // Free-running clock with a period of two time units.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #2000000;
    $display("tb_lowercase_count_rank_sort NOT OK");
    $finish;
  end

  // Update the predictor for one accepted request; push the ranking when asked to.
  task automatic rank_request(input lcrs_req_t r, input bit push_it);
    logic [15:0] cnt[MAX_STR];
    logic [3:0]  pos[MAX_STR];
    logic [15:0] key_cnt;
    logic [3:0]  key_pos;
    int          n;
    int          j;
    bit          full;
    full = strings_kept >= MAX_STR;
    case (r.func)
      FUNC_CHAR: begin
        if (!full && r.ch >= LC_FIRST && r.ch <= LC_LAST && open_count != COUNT_MAX)
          open_count++;
      end
      FUNC_CLOSE: begin
        if (!full) begin
          kept_count[strings_kept] = open_count;
          kept_pos[strings_kept]   = strings_kept[3:0];
          strings_kept++;
        end
        open_count = '0;
      end
      FUNC_FINISH: begin
        n = strings_kept;
        for (int i = 0; i < n; i++) begin
          cnt[i] = kept_count[i];
          pos[i] = kept_pos[i];
        end
        open_count   = '0;
        strings_kept = 0;
        // Stable insertion sort, highest count first.
        for (int i = 1; i < n; i++) begin
          key_cnt = cnt[i];
          key_pos = pos[i];
          j = i - 1;
          while (j >= 0) begin
            if (cnt[j] >= key_cnt) break;
            cnt[j + 1] = cnt[j];
            pos[j + 1] = pos[j];
            j--;
          end
          cnt[j + 1] = key_cnt;
          pos[j + 1] = key_pos;
        end
        if (push_it) begin
          if (n == 0) begin
            ranked_q.push_back('{string_index: 4'd0, lower_count: 16'd0,
                                 empty_res: 1'b1, last: 1'b1});
          end else begin
            for (int k = 0; k < n; k++)
              ranked_q.push_back('{string_index: pos[k], lower_count: cnt[k],
                                   empty_res: 1'b0, last: (k == n - 1)});
          end
        end
      end
      default: ;
    endcase
  endtask

  // Check results and predict on every accepted request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        if (ranked_q.size() == 0) begin
          $display("%0t: unexpected result idx=%0d cnt=%0d empty=%0b last=%0b", $time,
                   res_o.string_index, res_o.lower_count, res_o.empty_res, res_o.last);
          err_cnt++;
        end else begin
          if (res_o !== ranked_q[0]) begin
            $display("%0t: expected %0d/%0d/%0b/%0b, actual %0d/%0d/%0b/%0b %s",
                     $time, ranked_q[0].string_index, ranked_q[0].lower_count,
                     ranked_q[0].empty_res, ranked_q[0].last, res_o.string_index,
                     res_o.lower_count, res_o.empty_res, res_o.last,
                     "(idx/cnt/empty/last)");
            err_cnt++;
          end
          void'(ranked_q.pop_front());
          checked_cnt++;
        end
      end
      if (start && !busy) begin
        req_cnt++;
        if (req_i.func == FUNC_FINISH) finish_cnt++;
        rank_request(req_i, !typed_req);
        if (typed_req) ranked_q.push_back(typed_res);
      end
    end
  end

  // Random sender gaps, except inside the calm stretch.
  task automatic maybe_idle();
    if (!calm_run && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Issue one request and return at the edge that accepts it.
  task automatic send_item(input logic [1:0] func, input logic [7:0] ch,
                           input bit typed, input lcrs_res_t tres);
    maybe_idle();
    start     <= 1'b1;
    req_i     <= '{func: func, ch: ch};
    typed_req <= typed;
    typed_res <= tres;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off the sender until every predicted result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (ranked_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 70) return 8'($urandom_range(LC_FIRST, LC_LAST));
    return 8'($urandom_range(255));
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [7:0] ch, input int reps,
                         input bit typed, input lcrs_res_t res);
    stim_rows.push_back('{req: '{func: func, ch: ch}, reps: reps, typed: typed, res: res});
  endtask

  // One set of strings with random content, sometimes oversized or with stray requests.
  task automatic random_set();
    int roll;
    int n_str;
    int len;
    roll = $urandom_range(99);
    if (roll < 10) n_str = 0;
    else if (roll < 85) n_str = $urandom_range(1, 5);
    else n_str = $urandom_range(MAX_STR - 2, MAX_STR + 2);
    for (int s = 0; s < n_str; s++) begin
      len = $urandom_range(0, 6);
      for (int c = 0; c < len; c++) begin
        if ($urandom_range(99) < 5)
          send_item(FUNC_NONE, 8'($urandom_range(255)), 1'b0, '0);
        send_item(FUNC_CHAR, rand_char(), 1'b0, '0);
      end
      send_item(FUNC_CLOSE, 8'($urandom_range(255)), 1'b0, '0);
    end
    // Characters left open at the finish are dropped.
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_item(FUNC_CHAR, rand_char(), 1'b0, '0);
    send_item(FUNC_FINISH, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // Main sequence: reset, directed table, random sets, final drain.
  initial begin
    int set_cnt;
    int wait_cnt;
    set_cnt = 0;

    // Empty set straight after reset.
    add_row(FUNC_FINISH, 8'h00, 1, 1'b1,
            '{string_index: 4'd0, lower_count: 16'd0, empty_res: 1'b1, last: 1'b1});
    // Letter bounds, their neighbors and byte extremes.
    add_row(FUNC_CHAR, LC_FIRST, 1, 1'b0, '0);
    add_row(FUNC_CHAR, LC_LAST, 1, 1'b0, '0);
    add_row(FUNC_CHAR, 8'h60, 1, 1'b0, '0);
    add_row(FUNC_CHAR, 8'h7B, 1, 1'b0, '0);
    add_row(FUNC_CHAR, 8'h80, 1, 1'b0, '0);
    add_row(FUNC_CHAR, 8'hFF, 1, 1'b0, '0);
    add_row(FUNC_CHAR, 8'h00, 1, 1'b0, '0);
    add_row(FUNC_CLOSE, 8'h00, 1, 1'b0, '0);
    // An empty string, then two strings with equal counts.
    add_row(FUNC_CLOSE, 8'hFF, 1, 1'b0, '0);
    add_row(FUNC_CHAR, "m", 3, 1'b0, '0);
    add_row(FUNC_CLOSE, 8'h00, 1, 1'b0, '0);
    add_row(FUNC_CHAR, "q", 3, 1'b0, '0);
    add_row(FUNC_CLOSE, 8'h00, 1, 1'b0, '0);
    // Unclosed string and the unused code before the finish.
    add_row(FUNC_CHAR, "b", 5, 1'b0, '0);
    add_row(FUNC_NONE, 8'hFF, 1, 1'b0, '0);
    add_row(FUNC_FINISH, 8'hFF, 1, 1'b0, '0);
    // Full set: later characters and closes are ignored.
    add_row(FUNC_CLOSE, 8'h00, MAX_STR, 1'b0, '0);
    add_row(FUNC_CHAR, "x", 2, 1'b0, '0);
    add_row(FUNC_CLOSE, 8'h00, 1, 1'b0, '0);
    add_row(FUNC_FINISH, 8'h00, 1, 1'b0, '0);
    // Open characters only: still an empty set, and the count restarts after it.
    add_row(FUNC_CHAR, "a", 2, 1'b0, '0);
    add_row(FUNC_FINISH, 8'h00, 1, 1'b1,
            '{string_index: 4'd0, lower_count: 16'd0, empty_res: 1'b1, last: 1'b1});
    add_row(FUNC_CLOSE, 8'h00, 1, 1'b0, '0);
    add_row(FUNC_FINISH, 8'h00, 1, 1'b1,
            '{string_index: 4'd0, lower_count: 16'd0, empty_res: 1'b0, last: 1'b1});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed table runs as one long stretch with no sender gaps.
    calm_run = 1'b1;
    foreach (stim_rows[i]) begin
      for (int r = 0; r < stim_rows[i].reps; r++)
        send_item(stim_rows[i].req.func, stim_rows[i].req.ch,
                  stim_rows[i].typed, stim_rows[i].res);
    end
    calm_run = 1'b0;
    drain_results();

    // Random sets with sender gaps and a full drain now and then.
    while (req_cnt < 150) begin
      random_set();
      set_cnt++;
      if (set_cnt % 4 == 0) drain_results();
    end

    start <= 1'b0;
    @(posedge clk_i);
    wait_cnt = 0;
    while (ranked_q.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (ranked_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, ranked_q.size());
      err_cnt += ranked_q.size();
    end

    $display("Ran %0d requests in %0d random sets plus the directed table.",
             req_cnt, set_cnt);
    $display("Checked %0d results over %0d rankings, with empty, tied and full sets.",
             checked_cnt, finish_cnt);
    if (err_cnt == 0) begin
      $display("tb_lowercase_count_rank_sort OK");
    end else begin
      $display("tb_lowercase_count_rank_sort NOT OK");
    end
    $finish;
  end

endmodule

FILE: lowercase_count_rank_sort.f
hw/rtl/lcrs_pkg.sv
hw/rtl/lcrs_ram.sv
hw/rtl/lcrs_datapath.sv
hw/rtl/lcrs_ctrl.sv
hw/rtl/lowercase_count_rank_sort.sv
tb/tb_lowercase_count_rank_sort.sv
